FILE: sv/sbra_pkg.sv
// shared types and constants for the slab bitmap region allocator
`timescale 1ns / 1ps
`default_nettype none
package sbra_pkg;

    // pool geometry
    localparam int NUM_SLABS       = 16;
    localparam int SLAB_W          = 4;
    localparam int REGIONS_MAX     = 256;
    localparam int WORD_BITS       = 64;
    localparam int WORDS_PER_SLAB  = 4;
    localparam int ROW_COUNT       = NUM_SLABS * WORDS_PER_SLAB;
    localparam int ROW_W           = 6;

    // slab pointer with one extra code meaning no slab
    localparam logic [SLAB_W:0] NONE_SLAB = 5'd16;

    // register indexes
    localparam logic CFG_REGION_SIZE      = 1'b0;
    localparam logic CFG_REGIONS_PER_SLAB = 1'b1;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FREED     = 2'd1,
        ST_NO_SLAB   = 2'd2,
        ST_BAD_FREE  = 2'd3
    } status_t;

endpackage
`default_nettype wire

FILE: sv/sbra_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module sbra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/slab_bitmap_region_allocator.sv
// slab allocator with first-fit region bitmaps held in a ram
//
// channel   direction  signals                                transaction
// command   in         start, busy, op, free_slab,            start high while busy low
//                      free_offset
// result    out        done, status, slab_id, region_index,   one cycle strobe on done
//                      region_offset, slab_released
// config    in         cfg_we, cfg_index, cfg_data            cfg_we high
//
// an alloc holds busy for a read and a check step per 64-bit bitmap word, up to
// four words per slab and at most two slabs, plus a scan step and a pick step for
// each slab switch; the result strobe follows in the next cycle, as busy falls.
// a free rejected at once never raises busy; otherwise the divider steps, one per
// quotient bit, an index check with the ram read, the bit check, an unfull stack walk
// when the slab empties or leaves the full state, and a push when it leaves full.
// reset is asynchronous; the bitmap rows read as zero through per-row valid bits,
// so no clearing pass follows reset. results cannot be stalled: each is shown for
// exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module slab_bitmap_region_allocator (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 op,
    input  wire logic [3:0]           free_slab,
    input  wire logic [13:0]          free_offset,
    output logic                      done,
    output sbra_pkg::status_t         status,
    output logic [3:0]                slab_id,
    output logic [7:0]                region_index,
    output logic [13:0]               region_offset,
    output logic                      slab_released,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [14:0]          cfg_data
);
    import sbra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_PICK,
        S_A_SCAN,
        S_A_CHK,
        S_F_DIV,
        S_F_IDX,
        S_F_CHK,
        S_F_WALK,
        S_F_PUSH
    } state_t;

    state_t              state_reg;
    logic [SLAB_W-1:0]   s_reg;
    logic                fail_reg;
    logic [2:0]          w_reg;
    logic                push_reg;
    logic [13:0]         quo_reg;
    logic [14:0]         rem_reg;
    logic [3:0]          div_cnt_reg;
    logic [SLAB_W:0]     cur_reg;
    logic [SLAB_W:0]     prev_reg;
    logic [SLAB_W:0]     steps_reg;
    logic [8:0]          used_count_reg [NUM_SLABS];
    logic [NUM_SLABS-1:0] pool_reg;
    logic [SLAB_W:0]     next_reg [NUM_SLABS];
    logic [SLAB_W:0]     head_reg;
    logic [SLAB_W:0]     current_reg;
    logic [ROW_COUNT-1:0] rvalid_reg;
    logic [14:0]         region_size_reg;
    logic [8:0]          rps_reg;
    logic                done_reg;
    status_t             status_reg;
    logic [3:0]          slab_id_reg;
    logic [7:0]          region_index_reg;
    logic [13:0]         region_offset_reg;
    logic                released_reg;

    logic [8:0]          n_eff;
    logic [ROW_W-1:0]    row;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] avail;
    logic                ff_found;
    logic [5:0]          ff_bit;
    logic                ram_we;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                scan_ok;
    logic [15:0]         rem_sh;
    logic                rem_ge;
    logic [15:0]         rem_sub;
    logic [SLAB_W-1:0]   nrd_idx;
    logic [SLAB_W:0]     nrd;
    logic [8:0]          cnt_rd;
    logic [8:0]          cnt_dec;
    logic                pool_any;
    logic [SLAB_W-1:0]   pool_low;
    logic [7:0]          fin_idx;
    logic [22:0]         fin_prod;
    logic                bit_set;

    // effective region count, clamped to the bitmap size
    assign n_eff = (rps_reg > 9'(REGIONS_MAX)) ? 9'(REGIONS_MAX) : rps_reg;

    // bitmap row: slab number and word number
    always_comb
    begin
        if (state_reg == S_A_SCAN || state_reg == S_A_CHK)
        begin
            row = {s_reg, w_reg[1:0]};
        end
        else
        begin
            row = {s_reg, quo_reg[7:6]};
        end
    end

    assign word = rvalid_reg[row] ? ram_rdata : '0;

    // first free region in the word, regions past the count count as used
    assign lim_mask = (w_reg < n_eff[8:6]) ? '1 : ((64'd1 << n_eff[5:0]) - 64'd1);
    assign avail    = ~word & lim_mask;
    always_comb
    begin
        ff_found = 1'b0;
        ff_bit   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                ff_found = 1'b1;
                ff_bit   = 6'(b);
            end
        end
    end

    assign scan_ok = ({w_reg, 6'd0} < n_eff);
    assign bit_set = word[quo_reg[5:0]];

    // bitmap write back: set on alloc, clear on free
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = word;
        if (state_reg == S_A_CHK && ff_found)
        begin
            ram_we    = 1'b1;
            ram_wdata = word | (64'd1 << ff_bit);
        end
        else if (state_reg == S_F_CHK && bit_set)
        begin
            ram_we    = 1'b1;
            ram_wdata = word & ~(64'd1 << quo_reg[5:0]);
        end
    end

    sbra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROW_COUNT)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row),
        .wdata (ram_wdata),
        .raddr (row),
        .rdata (ram_rdata)
    );

    // restoring divider step
    assign rem_sh  = {rem_reg, quo_reg[13]};
    assign rem_ge  = (rem_sh >= {1'b0, region_size_reg});
    assign rem_sub = rem_sh - {1'b0, region_size_reg};

    // single read of the unfull links and of the use counts
    assign nrd_idx = (state_reg == S_A_PICK) ? head_reg[SLAB_W-1:0] : cur_reg[SLAB_W-1:0];
    assign nrd     = next_reg[nrd_idx];
    assign cnt_rd  = used_count_reg[s_reg];
    assign cnt_dec = (cnt_rd != 9'd0) ? (cnt_rd - 9'd1) : 9'd0;

    // lowest slab still in the pool
    always_comb
    begin
        pool_any = |pool_reg;
        pool_low = '0;
        for (int k = NUM_SLABS - 1; k >= 0; k--)
        begin
            if (pool_reg[k])
            begin
                pool_low = SLAB_W'(k);
            end
        end
    end

    // region offset of the finishing transaction
    assign fin_idx  = (state_reg == S_A_CHK) ? {w_reg[1:0], ff_bit} : quo_reg[7:0];
    assign fin_prod = fin_idx * region_size_reg;

    // sequencer, allocator state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            pool_reg        <= {{(NUM_SLABS-1){1'b1}}, 1'b0};
            head_reg        <= NONE_SLAB;
            current_reg     <= '0;
            rvalid_reg      <= '0;
            region_size_reg <= 15'd64;
            rps_reg         <= 9'd256;
            for (int k = 0; k < NUM_SLABS; k++)
            begin
                used_count_reg[k] <= '0;
                next_reg[k]       <= NONE_SLAB;
            end
        end
        else
        begin
            done_reg <= 1'b0;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REGION_SIZE:      region_size_reg <= cfg_data;
                    CFG_REGIONS_PER_SLAB: rps_reg         <= cfg_data[8:0];
                    default:              ;
                endcase
            end

            if (ram_we)
            begin
                rvalid_reg[row] <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        fail_reg <= 1'b0;
                        w_reg    <= '0;
                        if (op == OP_ALLOC)
                        begin
                            if (current_reg == NONE_SLAB)
                            begin
                                state_reg <= S_A_PICK;
                            end
                            else
                            begin
                                s_reg     <= current_reg[SLAB_W-1:0];
                                state_reg <= S_A_SCAN;
                            end
                        end
                        else if (pool_reg[free_slab] || region_size_reg == 15'd0)
                        begin
                            done_reg          <= 1'b1;
                            status_reg        <= ST_BAD_FREE;
                            slab_id_reg       <= free_slab;
                            region_index_reg  <= '0;
                            region_offset_reg <= '0;
                            released_reg      <= 1'b0;
                        end
                        else
                        begin
                            s_reg       <= free_slab;
                            quo_reg     <= free_offset;
                            rem_reg     <= '0;
                            div_cnt_reg <= '0;
                            state_reg   <= S_F_DIV;
                        end
                    end
                end

                // switch to the unfull head or a fresh pool slab
                S_A_PICK:
                begin
                    w_reg <= '0;
                    if (head_reg != NONE_SLAB)
                    begin
                        s_reg       <= head_reg[SLAB_W-1:0];
                        head_reg    <= nrd;
                        next_reg[head_reg[SLAB_W-1:0]] <= NONE_SLAB;
                        current_reg <= head_reg;
                        state_reg   <= S_A_SCAN;
                    end
                    else if (pool_any)
                    begin
                        s_reg                    <= pool_low;
                        pool_reg[pool_low]       <= 1'b0;
                        used_count_reg[pool_low] <= '0;
                        next_reg[pool_low]       <= NONE_SLAB;
                        current_reg              <= {1'b0, pool_low};
                        state_reg                <= S_A_SCAN;
                    end
                    else
                    begin
                        current_reg       <= NONE_SLAB;
                        done_reg          <= 1'b1;
                        status_reg        <= ST_NO_SLAB;
                        slab_id_reg       <= '0;
                        region_index_reg  <= '0;
                        region_offset_reg <= '0;
                        released_reg      <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                end

                // issue a bitmap word read or give up on this slab
                S_A_SCAN:
                begin
                    if (scan_ok)
                    begin
                        state_reg <= S_A_CHK;
                    end
                    else if (fail_reg)
                    begin
                        done_reg          <= 1'b1;
                        status_reg        <= ST_NO_SLAB;
                        slab_id_reg       <= '0;
                        region_index_reg  <= '0;
                        region_offset_reg <= '0;
                        released_reg      <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                    else
                    begin
                        fail_reg  <= 1'b1;
                        state_reg <= S_A_PICK;
                    end
                end

                // take the lowest free region of the word
                S_A_CHK:
                begin
                    if (ff_found)
                    begin
                        used_count_reg[s_reg] <= cnt_rd + 9'd1;
                        done_reg              <= 1'b1;
                        status_reg            <= ST_ALLOCATED;
                        slab_id_reg           <= s_reg;
                        region_index_reg      <= fin_idx;
                        region_offset_reg     <= fin_prod[13:0];
                        released_reg          <= 1'b0;
                        state_reg             <= S_IDLE;
                    end
                    else
                    begin
                        w_reg     <= w_reg + 3'd1;
                        state_reg <= S_A_SCAN;
                    end
                end

                // offset divided by region size, one quotient bit a cycle
                S_F_DIV:
                begin
                    rem_reg     <= rem_ge ? rem_sub[14:0] : rem_sh[14:0];
                    quo_reg     <= {quo_reg[12:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'd13)
                    begin
                        state_reg <= S_F_IDX;
                    end
                end

                // range check of the index, bitmap read issued here
                S_F_IDX:
                begin
                    if ({2'b00, quo_reg} < {7'd0, n_eff})
                    begin
                        state_reg <= S_F_CHK;
                    end
                    else
                    begin
                        done_reg          <= 1'b1;
                        status_reg        <= ST_BAD_FREE;
                        slab_id_reg       <= s_reg;
                        region_index_reg  <= '0;
                        region_offset_reg <= '0;
                        released_reg      <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                end

                // double free check and use count update
                S_F_CHK:
                begin
                    cur_reg   <= head_reg;
                    prev_reg  <= NONE_SLAB;
                    steps_reg <= '0;
                    if (!bit_set)
                    begin
                        done_reg          <= 1'b1;
                        status_reg        <= ST_BAD_FREE;
                        slab_id_reg       <= s_reg;
                        region_index_reg  <= '0;
                        region_offset_reg <= '0;
                        released_reg      <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                    else
                    begin
                        used_count_reg[s_reg] <= cnt_dec;
                        status_reg            <= ST_FREED;
                        slab_id_reg           <= s_reg;
                        region_index_reg      <= fin_idx;
                        region_offset_reg     <= fin_prod[13:0];
                        if (cnt_dec == 9'd0)
                        begin
                            pool_reg[s_reg] <= 1'b1;
                            if (current_reg == {1'b0, s_reg})
                            begin
                                current_reg <= NONE_SLAB;
                            end
                            released_reg <= 1'b1;
                            push_reg     <= 1'b0;
                            state_reg    <= S_F_WALK;
                        end
                        else if ({1'b0, cnt_dec} + 10'd1 == {1'b0, n_eff} &&
                                 current_reg != {1'b0, s_reg})
                        begin
                            released_reg <= 1'b0;
                            push_reg     <= 1'b1;
                            state_reg    <= S_F_WALK;
                        end
                        else
                        begin
                            released_reg <= 1'b0;
                            done_reg     <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                    end
                end

                // unlink the slab from the unfull stack, one link a cycle
                S_F_WALK:
                begin
                    if (cur_reg == NONE_SLAB || steps_reg == 5'(NUM_SLABS))
                    begin
                        next_reg[s_reg] <= NONE_SLAB;
                        if (push_reg)
                        begin
                            state_reg <= S_F_PUSH;
                        end
                        else
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (cur_reg == {1'b0, s_reg})
                    begin
                        if (prev_reg == NONE_SLAB)
                        begin
                            head_reg <= nrd;
                        end
                        else
                        begin
                            next_reg[prev_reg[SLAB_W-1:0]] <= nrd;
                        end
                        cur_reg <= NONE_SLAB;
                    end
                    else
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= nrd;
                        steps_reg <= steps_reg + 5'd1;
                    end
                end

                // push the slab that left the full state
                S_F_PUSH:
                begin
                    next_reg[s_reg] <= head_reg;
                    head_reg        <= {1'b0, s_reg};
                    done_reg        <= 1'b1;
                    state_reg       <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign slab_id       = slab_id_reg;
    assign region_index  = region_index_reg;
    assign region_offset = region_offset_reg;
    assign slab_released = released_reg;

`ifndef SYNTHESIS
    // a result only appears once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // a release is only reported for a successful free
    a_release_free: assert property (@(posedge clk) disable iff (!rst_n)
        (done && slab_released) |-> (status == ST_FREED))
        else $error("slab release on a non-free result");

    // the slab handed out is never in the pool
    a_alloc_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_ALLOCATED) |-> !pool_reg[slab_id])
        else $error("allocation from a pool slab");

    // the current slab is never in the pool
    a_current_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (current_reg != NONE_SLAB) |-> !pool_reg[current_reg[SLAB_W-1:0]])
        else $error("current slab is in the pool");
`endif

endmodule
`default_nettype wire

FILE: dv/slab_bitmap_region_allocator_tb.sv
// self-checking testbench for the slab bitmap region allocator
`timescale 1ns / 1ps
module slab_bitmap_region_allocator_tb;
    import sbra_pkg::*;

    localparam int DATA_BYTES = 16384;
    localparam int NO_SLAB    = NUM_SLABS;

    typedef struct packed {
        logic        op;
        logic [3:0]  slab;
        logic [13:0] offset;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  slab_id;
        logic [7:0]  index;
        logic [13:0] offset;
        logic        released;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic op = OP_ALLOC;
    logic [3:0] free_slab = '0;
    logic [13:0] free_offset = '0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_REGION_SIZE;
    logic [14:0] cfg_data = '0;
    wire busy, done, slab_released;
    status_t status;
    wire [3:0] slab_id;
    wire [7:0] region_index;
    wire [13:0] region_offset;

    slab_bitmap_region_allocator uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .free_slab(free_slab), .free_offset(free_offset), .done(done),
        .status(status), .slab_id(slab_id), .region_index(region_index),
        .region_offset(region_offset), .slab_released(slab_released),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // allocator shadow state
    logic [255:0] shadow_bits [NUM_SLABS];
    int unsigned shadow_count [NUM_SLABS];
    bit shadow_pool [NUM_SLABS];
    bit shadow_full [NUM_SLABS];
    int unsigned shadow_next [NUM_SLABS];
    int unsigned shadow_head;
    int unsigned shadow_current;
    int unsigned shadow_rsize;
    int unsigned shadow_rcount;

    request_t pending_requests[$];
    outcome_t expected_outcomes[$];
    int errors = 0;
    bit stimulus_done = 1'b0;
    bit hold_requests = 1'b0;
    bit cfg_pending = 1'b0;
    logic cfg_req_index;
    logic [14:0] cfg_req_data;

    function automatic void wipe_slab(int unsigned s);
        shadow_bits[s] = '0;
        shadow_count[s] = 0;
        shadow_full[s] = 1'b0;
        shadow_next[s] = NO_SLAB;
    endfunction

    function automatic void shadow_reset();
        for (int s = 0; s < NUM_SLABS; s++)
        begin
            wipe_slab(s);
            shadow_pool[s] = 1'b1;
        end
        shadow_head = NO_SLAB;
        shadow_pool[0] = 1'b0;
        shadow_current = 0;
        shadow_rsize = 64;
        shadow_rcount = 256;
    endfunction

    function automatic void unlink_unfull(int unsigned s);
        int unsigned prev, cur, steps;
        prev = NO_SLAB;
        cur = shadow_head;
        steps = 0;
        while (cur < NUM_SLABS && steps < NUM_SLABS)
        begin
            if (cur == s)
            begin
                if (prev == NO_SLAB)
                    shadow_head = shadow_next[cur];
                else
                    shadow_next[prev] = shadow_next[cur];
                shadow_next[cur] = NO_SLAB;
                return;
            end
            prev = cur;
            cur = shadow_next[cur];
            steps++;
        end
    endfunction

    function automatic int unsigned switch_slab();
        int unsigned s;
        if (shadow_head < NUM_SLABS)
        begin
            s = shadow_head;
            shadow_head = shadow_next[s];
            shadow_next[s] = NO_SLAB;
            shadow_current = s;
            return s;
        end
        for (s = 0; s < NUM_SLABS; s++)
            if (shadow_pool[s])
            begin
                shadow_pool[s] = 1'b0;
                wipe_slab(s);
                shadow_current = s;
                return s;
            end
        shadow_current = NO_SLAB;
        return NO_SLAB;
    endfunction

    function automatic int unsigned first_clear(int unsigned s, int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            if (!shadow_bits[s][i])
                return i;
        return n;
    endfunction

    // predicted outcome of one request, updating the shadow state
    function automatic outcome_t allocate_or_free(request_t r);
        outcome_t o;
        int unsigned n, s, idx, off;
        longint unsigned prod;
        n = shadow_rcount > REGIONS_MAX ? REGIONS_MAX : shadow_rcount;
        o = '0;
        idx = 0;
        if (r.op == OP_ALLOC)
        begin
            s = shadow_current;
            if (s >= NUM_SLABS)
                s = switch_slab();
            if (s < NUM_SLABS)
            begin
                idx = first_clear(s, n);
                if (idx >= n)
                begin
                    shadow_full[s] = 1'b1;
                    s = switch_slab();
                    if (s < NUM_SLABS)
                        idx = first_clear(s, n);
                end
            end
            if (s >= NUM_SLABS || idx >= n)
                o.status = ST_NO_SLAB;
            else
            begin
                shadow_bits[s][idx] = 1'b1;
                shadow_count[s]++;
                if (shadow_count[s] == n)
                    shadow_full[s] = 1'b1;
                o.status = ST_ALLOCATED;
                o.slab_id = s;
                o.index = idx;
                prod = longint'(idx) * shadow_rsize;
                o.offset = prod[13:0];
            end
        end
        else
        begin
            s = r.slab;
            off = r.offset;
            o.slab_id = r.slab;
            o.status = ST_BAD_FREE;
            if (!shadow_pool[s] && shadow_rsize != 0 && off < DATA_BYTES)
            begin
                idx = off / shadow_rsize;
                if (idx < n && shadow_bits[s][idx])
                begin
                    o.status = ST_FREED;
                    o.index = idx;
                    prod = longint'(idx) * shadow_rsize;
                    o.offset = prod[13:0];
                    shadow_bits[s][idx] = 1'b0;
                    if (shadow_count[s] > 0)
                        shadow_count[s]--;
                    if (shadow_count[s] == 0)
                    begin
                        unlink_unfull(s);
                        wipe_slab(s);
                        shadow_pool[s] = 1'b1;
                        if (shadow_current == s)
                            shadow_current = NO_SLAB;
                        o.released = 1'b1;
                    end
                    else if (shadow_count[s] + 1 == n && shadow_current != s)
                    begin
                        shadow_full[s] = 1'b0;
                        unlink_unfull(s);
                        shadow_next[s] = shadow_head;
                        shadow_head = s;
                    end
                end
            end
        end
        return o;
    endfunction

    // pick a free target that is mostly a live region of some slab
    function automatic request_t live_free();
        request_t r;
        int unsigned s, i, tries;
        r.op = OP_FREE;
        r.slab = $urandom_range(0, 15);
        r.offset = $urandom_range(0, 16383);
        for (tries = 0; tries < 32; tries++)
        begin
            s = $urandom_range(0, 15);
            if (!shadow_pool[s] && shadow_count[s] != 0)
            begin
                i = $urandom_range(0, 255);
                while (!shadow_bits[s][i])
                    i = (i + 1) % 256;
                r.slab = s;
                r.offset = (i * shadow_rsize + $urandom_range(0, shadow_rsize - 1)) % 16384;
                return r;
            end
        end
        return r;
    endfunction

    // driver: one transaction per accepted start, random gaps between
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_pending && !start)
            begin
                cfg_we <= 1'b1;
                cfg_index <= cfg_req_index;
                cfg_data <= cfg_req_data;
                cfg_pending <= 1'b0;
            end
            else
                cfg_we <= 1'b0;
            if (start && !busy)
            begin
                start <= 1'b0;
                gap_left <= $urandom_range(0, 4);
            end
            else if (!start)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_requests.size() != 0 && !hold_requests && !cfg_pending)
                begin
                    request_t r;
                    r = pending_requests.pop_front();
                    expected_outcomes.push_back(allocate_or_free(r));
                    op <= r.op;
                    free_slab <= r.slab;
                    free_offset <= r.offset;
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            outcome_t e;
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t unexpected result status %0d slab %0d", $time, status, slab_id);
                errors++;
            end
            else
            begin
                e = expected_outcomes.pop_front();
                if (status !== e.status || slab_id !== e.slab_id
                    || region_index !== e.index || region_offset !== e.offset
                    || slab_released !== e.released)
                begin
                    $display("%0t mismatch expected st %0d slab %0d idx %0d off %0d rel %0d",
                             $time, e.status, e.slab_id, e.index, e.offset, e.released);
                    $display("%0t          actual   st %0d slab %0d idx %0d off %0d rel %0d",
                             $time, status, slab_id, region_index, region_offset,
                             slab_released);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_requests.size() != 0 || expected_outcomes.size() != 0 || start)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // write one register between phases, shadow follows at once
    task automatic set_register(logic idx, int unsigned value);
        drain();
        cfg_req_index = idx;
        cfg_req_data = value[14:0];
        cfg_pending = 1'b1;
        while (cfg_pending || cfg_we)
            @(posedge clk);
        if (idx == CFG_REGION_SIZE)
            shadow_rsize = value & 32'h7fff;
        else
            shadow_rcount = value & 32'h1ff;
    endtask

    // random phase; shadow used for targeting runs ahead only by what is queued
    task automatic random_phase(int count, int free_pct);
        request_t r;
        for (int k = 0; k < count; k++)
        begin
            while (pending_requests.size() > 2)
                @(posedge clk);
            if ($urandom_range(0, 99) < free_pct)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    r.op = OP_FREE;
                    r.slab = $urandom_range(0, 15);
                    r.offset = $urandom_range(0, 16383);
                end
                else
                begin
                    drain_queue_only();
                    r = live_free();
                end
            end
            else
            begin
                r.op = OP_ALLOC;
                r.slab = $urandom_range(0, 15);
                r.offset = $urandom_range(0, 16383);
            end
            pending_requests.push_back(r);
        end
    endtask

    // live frees are chosen from the shadow once queued requests are predicted
    task automatic drain_queue_only();
        while (pending_requests.size() != 0)
            @(posedge clk);
    endtask

    task automatic push(logic o, logic [3:0] s, logic [13:0] off);
        request_t r;
        r.op = o;
        r.slab = s;
        r.offset = off;
        pending_requests.push_back(r);
    endtask

    initial
    begin
        shadow_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and each special case
        push(OP_ALLOC, 4'd0, 14'd0);
        push(OP_ALLOC, 4'd15, 14'h3fff);
        push(OP_FREE, 4'd0, 14'd64);
        push(OP_FREE, 4'd0, 14'd64);
        push(OP_FREE, 4'd15, 14'd0);
        push(OP_FREE, 4'd0, 14'h3fff);
        push(OP_FREE, 4'd0, 14'd0);
        push(OP_FREE, 4'd0, 14'd0);
        push(OP_ALLOC, 4'd0, 14'd0);
        set_register(CFG_REGIONS_PER_SLAB, 0);
        push(OP_ALLOC, 4'd0, 14'd0);
        push(OP_FREE, 4'd0, 14'd0);
        set_register(CFG_REGIONS_PER_SLAB, 511);
        set_register(CFG_REGION_SIZE, 0);
        push(OP_ALLOC, 4'd0, 14'd0);
        push(OP_FREE, 4'd0, 14'd0);
        set_register(CFG_REGION_SIZE, 32767);
        push(OP_ALLOC, 4'd0, 14'd0);
        push(OP_FREE, 4'd1, 14'd0);

        // one region per slab: fills the pool quickly and exhausts it
        set_register(CFG_REGIONS_PER_SLAB, 1);
        set_register(CFG_REGION_SIZE, 1);
        for (int k = 0; k < 18; k++)
            push(OP_ALLOC, 4'd0, 14'd0);

        // sender pauses halfway until every expected result has come
        while (pending_requests.size() > 9)
            @(posedge clk);
        hold_requests = 1'b1;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        hold_requests = 1'b0;
        random_phase(150, 45);

        // several register settings with random traffic
        set_register(CFG_REGIONS_PER_SLAB, 3);
        set_register(CFG_REGION_SIZE, 100);
        random_phase(350, 45);
        set_register(CFG_REGIONS_PER_SLAB, 256);
        set_register(CFG_REGION_SIZE, 64);
        random_phase(300, 30);
        set_register(CFG_REGIONS_PER_SLAB, 17);
        set_register(CFG_REGION_SIZE, 16384);
        random_phase(300, 48);
        set_register(CFG_REGIONS_PER_SLAB, 300);
        set_register(CFG_REGION_SIZE, 7);
        random_phase(350, 50);

        drain();
        stimulus_done = 1'b1;
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: files.f
sv/sbra_pkg.sv
sv/sbra_ram.sv
sv/slab_bitmap_region_allocator.sv
dv/slab_bitmap_region_allocator_tb.sv
